/* rtl/sfa_pkg.sv */
// ----------------------------------------------------------------------------
// Segment fit allocator package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

  localparam int unsigned LEN_W      = 25;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE = 1'b1;

  localparam logic FIT_LOWEST   = 1'b0;
  localparam logic FIT_SMALLEST = 1'b1;

  localparam logic [LEN_W-1:0] MEM_SIZE_RESET = 25'd4096;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic shift_init;
    logic shift_step;
    logic insert;
    logic out_load;
    logic out_grant;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic scan_last;
    logic ff_hit;
    logic found;
    logic shift_none;
    logic shift_last;
  } status_t;

endpackage

`default_nettype wire

/* rtl/sfa_ctrl.sv */
// ----------------------------------------------------------------------------
// Segment fit allocator controller
// Sequences the gap scan and, when a gap is found, the table shift and the
// insert for each request that is not refused, and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  input  sfa_pkg::status_t status_i,
  output sfa_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   grant_q, grant_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    grant_d     = grant_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (status_i.req_bad) begin
            grant_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last || status_i.ff_hit) begin
          if (status_i.found) begin
            state_d = ST_PREP;
          end else begin
            grant_d = 1'b0;
            state_d = ST_DONE;
          end
        end
      end
      ST_PREP: begin
        cmd_o.shift_init = 1'b1;
        state_d = status_i.shift_none ? ST_INSERT : ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (status_i.shift_last) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        grant_d      = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_grant = grant_q;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grant_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grant_q     <= grant_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/sfa_datapath.sv */
// ----------------------------------------------------------------------------
// Segment fit allocator datapath
// Holds the configuration, the sorted segment table memory, the gap
// evaluation logic and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_datapath #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned ADDR_BITS    = 24
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [sfa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [sfa_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire  [sfa_pkg::LEN_W-1:0]           request_size_i,
  input  sfa_pkg::cmd_t                       cmd_i,
  output sfa_pkg::status_t                    status_o,
  output logic                                granted_o,
  output logic [ADDR_BITS-1:0]                segment_base_o
);

  localparam int unsigned LW      = sfa_pkg::LEN_W;
  localparam int unsigned AW      = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SUM_W   = ((ADDR_BITS > LW) ? ADDR_BITS : LW) + 1;
  localparam int unsigned ENTRY_W = ADDR_BITS + LW;
  localparam logic [SUM_W-1:0] ADDR_SPAN = SUM_W'(1) << ADDR_BITS;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_SEGMENTS);

  logic [ENTRY_W-1:0]   mem_q [MAX_SEGMENTS];
  logic [ENTRY_W-1:0]   rd_data_q;

  logic                 fit_mode_q;
  logic [LW-1:0]        mem_size_q;
  logic [SUM_W-1:0]     mem_end;
  logic [CNT_W-1:0]     cnt_q;
  logic                 found_q;

  logic [CNT_W-1:0]     idx_q;
  logic [LW-1:0]        req_q;
  logic [SUM_W-1:0]     prev_end_q;
  logic [CNT_W-1:0]     chosen_q;
  logic [SUM_W-1:0]     best_q;
  logic [ADDR_BITS-1:0] base_q;

  logic                 rd_en;
  logic [CNT_W-1:0]     rd_idx;
  logic                 wr_en;
  logic [CNT_W-1:0]     wr_idx;
  logic [ENTRY_W-1:0]   wr_data;

  logic [ADDR_BITS-1:0] rd_base;
  logic [LW-1:0]        rd_len;
  logic [SUM_W-1:0]     hi_raw, hi, lo, gap_size;
  logic                 fit, better, take;

  assign rd_base = rd_data_q[ENTRY_W-1:LW];
  assign rd_len  = rd_data_q[LW-1:0];

  always_comb begin
    lo       = prev_end_q;
    hi_raw   = (idx_q == cnt_q) ? mem_end : SUM_W'(rd_base);
    hi       = (hi_raw > mem_end) ? mem_end : hi_raw;
    gap_size = (hi > lo) ? (hi - lo) : '0;
    fit      = (gap_size != '0) && (gap_size >= SUM_W'(req_q));
    better   = !found_q || (gap_size < best_q);
    take     = fit && ((fit_mode_q == sfa_pkg::FIT_LOWEST) || better);
  end

  always_comb begin
    status_o            = '0;
    status_o.req_bad    = (request_size_i == '0) || (cnt_q == FULL_COUNT);
    status_o.scan_last  = (idx_q == cnt_q);
    status_o.ff_hit     = fit && (fit_mode_q == sfa_pkg::FIT_LOWEST);
    status_o.found      = found_q || fit;
    status_o.shift_none = (cnt_q == chosen_q);
    status_o.shift_last = ((idx_q - CNT_W'(1)) == chosen_q);
  end

  always_comb begin
    rd_en   = cmd_i.start || cmd_i.scan_step || cmd_i.shift_init || cmd_i.shift_step;
    rd_idx  = '0;
    wr_en   = cmd_i.shift_step || cmd_i.insert;
    wr_idx  = cmd_i.insert ? chosen_q : idx_q;
    wr_data = cmd_i.insert ? {base_q, req_q} : rd_data_q;
    priority if (cmd_i.scan_step) begin
      rd_idx = idx_q + CNT_W'(1);
    end else if (cmd_i.shift_init) begin
      rd_idx = cnt_q - CNT_W'(1);
    end else if (cmd_i.shift_step) begin
      rd_idx = idx_q - CNT_W'(2);
    end else begin
      rd_idx = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  assign mem_end = (SUM_W'(mem_size_q) > ADDR_SPAN) ? ADDR_SPAN : SUM_W'(mem_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= sfa_pkg::FIT_LOWEST;
      mem_size_q <= sfa_pkg::MEM_SIZE_RESET;
      cnt_q      <= '0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sfa_pkg::CFG_FIT_MODE:    fit_mode_q <= cfg_data_i[0];
          sfa_pkg::CFG_MEMORY_SIZE: mem_size_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_step && take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.insert) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q      <= request_size_i;
      idx_q      <= '0;
      prev_end_q <= '0;
    end
    if (cmd_i.scan_step) begin
      idx_q      <= idx_q + CNT_W'(1);
      prev_end_q <= SUM_W'(rd_base) + SUM_W'(rd_len);
      if (take) begin
        chosen_q <= idx_q;
        best_q   <= gap_size;
        base_q   <= lo[ADDR_BITS-1:0];
      end
    end
    if (cmd_i.shift_init) begin
      idx_q <= cnt_q;
    end
    if (cmd_i.shift_step) begin
      idx_q <= idx_q - CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      granted_o      <= cmd_i.out_grant;
      segment_base_o <= cmd_i.out_grant ? base_q : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/segment_fit_allocator.sv */
// ----------------------------------------------------------------------------
// Segment fit allocator
// Allocates segments from a sorted occupancy table by first fit or best fit.
// ----------------------------------------------------------------------------
// A request that names a size of zero, or arrives while the table holds
// MAX_SEGMENTS entries, is refused. Otherwise the block walks the free gaps
// one per cycle through the single-port read of the segment table, then moves
// the entries above the chosen gap up by one entry per cycle. The next request
// is taken as soon as the result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module segment_fit_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned ADDR_BITS    = 24
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [sfa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [sfa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [sfa_pkg::LEN_W-1:0]       request_size_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic                            granted_o,
  output logic [ADDR_BITS-1:0]            segment_base_o
);

  sfa_pkg::cmd_t    cmd;
  sfa_pkg::status_t status;

  sfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .request_size_i (request_size_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .granted_o      (granted_o),
    .segment_base_o (segment_base_o)
  );

`ifndef SYNTHESIS
  a_base_zero_on_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> segment_base_o == '0)
    else $error("Refused request carries a nonzero base.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block took no time to work on an accepted request.");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared without a request in progress.");
`endif

endmodule

`default_nettype wire
